// ===== sv/ppurf_pkg.sv =====
// Shared constants, types and helpers of the picture-unit CPU register file.
package ppurf_pkg;

    localparam int unsigned VRAM_DEPTH_DEF = 16384;
    localparam int unsigned OAM_DEPTH      = 256;
    localparam int unsigned OAM_AW         = $clog2(OAM_DEPTH);
    localparam int unsigned REG_COUNT      = 8;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [15:0] STEP_ACROSS   = 16'd1;
    localparam logic [15:0] STEP_DOWN     = 16'd32;
    localparam logic [8:0]  SCROLL_Y_PAGE = 9'd240;

    typedef logic [REG_COUNT-1:0][7:0] t_reg_file;

    // Reduces a data address to a VRAM word index: 14-bit mask, then a
    // four-step restoring remainder, since the depth is at least 1/16 of 16 KiB.
    function automatic logic [13:0] vram_index(input logic [15:0] addr,
                                               input logic [17:0] depth);
        logic [17:0] rem;
        logic [17:0] sub;
        rem = {4'b0, addr[13:0]};
        for (int k = 3; k >= 0; k--) begin
            sub = depth << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[13:0];
    endfunction

endpackage

// ===== sv/ppu_cpu_register_file_unit.sv =====
// Top level of the picture-unit CPU register file: control, address state and memories.
//
//  Channel   Direction  Handshake                  Payload
//  request   in         i_in_valid / o_in_ready    i_func, i_reg_index, i_write_data
//  response  out        o_out_valid / i_out_ready  o_read_data, o_scroll_x, o_scroll_y,
//                                                  o_current_vram_addr
//
// A register access is answered from the response register directly; an OAM data read
// or a data-port read goes through ST_MEM, since the OAM and VRAM reads are registered.
// One beat is in flight at a time; a new request is taken when the response register
// is empty or is being emptied in the same cycle.
// Reset clears the register bytes, toggle, addresses and read buffer; the memories
// are not cleared and hold garbage until written.
module ppu_cpu_register_file_unit #(
    parameter int unsigned VRAM_DEPTH = ppurf_pkg::VRAM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [2:0]  i_reg_index,
    input  logic [7:0]  i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_read_data,
    output logic [8:0]  o_scroll_x,
    output logic [8:0]  o_scroll_y,
    output logic [14:0] o_current_vram_addr
);

    localparam int unsigned VRAM_AW      = $clog2(VRAM_DEPTH);
    localparam logic [17:0] VRAM_DEPTH_W = 18'(VRAM_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_MEM
    } t_state;

    t_state                 r_state, n_state;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_read_data, n_read_data;
    logic                   r_mem_vram, n_mem_vram;
    ppurf_pkg::t_reg_file   r_reg_bytes, n_reg_bytes;
    logic [7:0]             r_read_buffer, n_read_buffer;
    logic [15:0]            r_data_addr, n_data_addr;
    logic                   r_toggle, n_toggle;
    logic [14:0]            r_temp, n_temp;
    logic [14:0]            r_cur, n_cur;
    logic [2:0]             r_fine_x, n_fine_x;
    logic [7:0]             r_scroll_y_byte, n_scroll_y_byte;

    logic                   accept;
    logic                   out_free;
    logic [15:0]            step_size;
    logic [13:0]            vram_idx;
    logic                   oam_we, oam_re, vram_we, vram_re;
    logic [7:0]             oam_rdata, vram_rdata;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;
    assign step_size  = r_reg_bytes[ppurf_pkg::REG_CTRL][2] ? ppurf_pkg::STEP_DOWN
                                                            : ppurf_pkg::STEP_ACROSS;
    assign vram_idx   = ppurf_pkg::vram_index(r_data_addr, VRAM_DEPTH_W);

    ppurf_ram #(
        .DEPTH (ppurf_pkg::OAM_DEPTH),
        .AW    (ppurf_pkg::OAM_AW)
    ) u_oam (
        .i_clk   (i_clk),
        .i_we    (oam_we),
        .i_re    (oam_re),
        .i_addr  (r_reg_bytes[ppurf_pkg::REG_OAM_ADDR][ppurf_pkg::OAM_AW-1:0]),
        .i_wdata (i_write_data),
        .o_rdata (oam_rdata)
    );

    ppurf_ram #(
        .DEPTH (VRAM_DEPTH),
        .AW    (VRAM_AW)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (vram_we),
        .i_re    (vram_re),
        .i_addr  (vram_idx[VRAM_AW-1:0]),
        .i_wdata (i_write_data),
        .o_rdata (vram_rdata)
    );

    always_comb begin
        n_state         = r_state;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_read_data     = r_read_data;
        n_mem_vram      = r_mem_vram;
        n_reg_bytes     = r_reg_bytes;
        n_read_buffer   = r_read_buffer;
        n_data_addr     = r_data_addr;
        n_toggle        = r_toggle;
        n_temp          = r_temp;
        n_cur           = r_cur;
        n_fine_x        = r_fine_x;
        n_scroll_y_byte = r_scroll_y_byte;
        oam_we          = 1'b0;
        oam_re          = 1'b0;
        vram_we         = 1'b0;
        vram_re         = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == ppurf_pkg::FUNC_READ) begin
                        unique case (i_reg_index)
                            ppurf_pkg::REG_OAM_DATA: begin
                                oam_re      = 1'b1;
                                n_mem_vram  = 1'b0;
                                n_out_valid = 1'b0;
                                n_state     = ST_MEM;
                            end
                            ppurf_pkg::REG_DATA: begin
                                vram_re     = 1'b1;
                                n_read_data = r_read_buffer;
                                n_data_addr = r_data_addr + step_size;
                                n_mem_vram  = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = ST_MEM;
                            end
                            default: begin
                                if (i_reg_index == ppurf_pkg::REG_STATUS) begin
                                    n_toggle = 1'b0;
                                end
                                n_read_data = r_reg_bytes[i_reg_index];
                                n_out_valid = 1'b1;
                            end
                        endcase
                    end else begin
                        n_read_data = 8'd0;
                        n_out_valid = 1'b1;
                        unique case (i_reg_index)
                            ppurf_pkg::REG_CTRL: begin
                                n_temp[11:10] = i_write_data[1:0];
                                n_reg_bytes[ppurf_pkg::REG_CTRL] = i_write_data;
                            end
                            ppurf_pkg::REG_MASK,
                            ppurf_pkg::REG_STATUS,
                            ppurf_pkg::REG_OAM_ADDR: begin
                                n_reg_bytes[i_reg_index] = i_write_data;
                            end
                            ppurf_pkg::REG_OAM_DATA: begin
                                oam_we = 1'b1;
                                n_reg_bytes[ppurf_pkg::REG_OAM_ADDR] =
                                    r_reg_bytes[ppurf_pkg::REG_OAM_ADDR] + 8'd1;
                            end
                            ppurf_pkg::REG_SCROLL: begin
                                if (!r_toggle) begin
                                    n_temp   = {r_temp[14:5], i_write_data[7:3]};
                                    n_fine_x = i_write_data[2:0];
                                end else begin
                                    n_temp = {i_write_data[2:0], r_temp[11:10],
                                              i_write_data[7:3], r_temp[4:0]};
                                    n_scroll_y_byte = i_write_data;
                                end
                                n_toggle = !r_toggle;
                            end
                            ppurf_pkg::REG_ADDR: begin
                                if (!r_toggle) begin
                                    n_temp = {1'b0, i_write_data[5:0], r_temp[7:0]};
                                end else begin
                                    n_temp = {r_temp[14:8], i_write_data};
                                    n_cur  = {r_temp[14:8], i_write_data};
                                end
                                n_data_addr = {r_data_addr[7:0], i_write_data};
                                n_toggle    = !r_toggle;
                            end
                            ppurf_pkg::REG_DATA: begin
                                vram_we     = 1'b1;
                                n_data_addr = r_data_addr + step_size;
                            end
                        endcase
                    end
                end
            end
            ST_MEM: begin
                if (r_mem_vram) begin
                    n_read_buffer = vram_rdata;
                end else begin
                    n_read_data = oam_rdata;
                end
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_reg_bytes     <= '0;
            r_read_buffer   <= 8'd0;
            r_data_addr     <= 16'd0;
            r_toggle        <= 1'b0;
            r_temp          <= 15'd0;
            r_cur           <= 15'd0;
            r_fine_x        <= 3'd0;
            r_scroll_y_byte <= 8'd0;
        end else begin
            r_state         <= n_state;
            r_out_valid     <= n_out_valid;
            r_reg_bytes     <= n_reg_bytes;
            r_read_buffer   <= n_read_buffer;
            r_data_addr     <= n_data_addr;
            r_toggle        <= n_toggle;
            r_temp          <= n_temp;
            r_cur           <= n_cur;
            r_fine_x        <= n_fine_x;
            r_scroll_y_byte <= n_scroll_y_byte;
        end
        r_read_data <= n_read_data;
        r_mem_vram  <= n_mem_vram;
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_scroll_x          = {r_temp[10], r_temp[4:0], r_fine_x};
    assign o_scroll_y          = (r_reg_bytes[ppurf_pkg::REG_CTRL][1] ?
                                  ppurf_pkg::SCROLL_Y_PAGE : 9'd0)
                                 + {1'b0, r_scroll_y_byte};
    assign o_current_vram_addr = r_cur;

endmodule

// ===== sv/ppurf_ram.sv =====
// Single-port synchronous RAM with a registered read port.
module ppurf_ram #(
    parameter int unsigned DEPTH = ppurf_pkg::OAM_DEPTH,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic [7:0]    i_wdata,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
